// ===== rtl/qoi_variant_image_decoder_core_assert.svh =====
// Assertion macros for the QOI variant image decoder core.
`ifndef QOI_VARIANT_IMAGE_DECODER_CORE_ASSERT_SVH
`define QOI_VARIANT_IMAGE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked on aclk outside reset.
`define QOIVID_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("qoivid assertion failed");

// Next-cycle implication, checked on aclk outside reset.
`define QOIVID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("qoivid assertion failed");

`endif

// ===== rtl/qoivid_pkg.sv =====
// Types and constants shared by the QOI variant image decoder.
`default_nettype none

package qoivid_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_OP      = 3'd1,
        PH_BYTE2   = 3'd2,
        PH_BYTE3   = 3'd3,
        PH_LITERAL = 3'd4,
        PH_FULL    = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_MAGIC  = 3'd1,
        ST_ZERO_SIZE  = 3'd2,
        ST_SHORT_HDR  = 3'd3,
        ST_TRUNC_OP   = 3'd4,
        ST_INCOMPLETE = 3'd5
    } status_t;

    typedef struct packed {
        logic        en;
        logic [5:0]  addr;
        logic [31:0] data;
    } idx_wr_t;

    localparam logic [3:0]  HDR_LAST     = 4'd11;
    localparam logic [3:0]  HDR_DONE     = 4'd12;
    localparam logic [31:0] PIXEL_RESET  = 32'hFF00_0000;
    localparam logic [13:0] LONG_RUN_BIAS = 14'd32;

    localparam logic [7:0] OP_RUN       = 8'h40;
    localparam logic [7:0] OP_LONG_RUN  = 8'h60;
    localparam logic [7:0] OP_DELTA     = 8'h80;
    localparam logic [7:0] OP_MEDIUM    = 8'hC0;
    localparam logic [7:0] OP_WIDE      = 8'hE0;
    localparam logic [7:0] OP_LITERAL   = 8'hF0;

    function automatic logic [7:0] magic_byte(input logic [1:0] pos);
        logic [7:0] m;
        case (pos)
            2'd0:    m = 8'h66;
            2'd1:    m = 8'h69;
            2'd2:    m = 8'h6F;
            2'd3:    m = 8'h71;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qoivid_index.sv =====
// 64-entry color index with per-entry valid bits, bulk clear and write bypass.
`default_nettype none

module qoivid_index (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               rd_en,
    input  wire logic [5:0]         rd_addr,
    input  wire qoivid_pkg::idx_wr_t wr,
    input  wire logic               clr,
    output logic [31:0]             rd_data,
    output logic                    rd_hit
);

    logic [31:0] mem [64];
    logic [63:0] valid_reg;
    logic [31:0] rd_data_reg;
    logic        rd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= (wr.en && wr.addr == rd_addr) ? wr.data : mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end else begin
            if (clr) begin
                valid_reg <= '0;
            end else if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en) begin
                if (clr) begin
                    rd_hit_reg <= 1'b0;
                end else if (wr.en && wr.addr == rd_addr) begin
                    rd_hit_reg <= 1'b1;
                end else begin
                    rd_hit_reg <= valid_reg[rd_addr];
                end
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_hit  = rd_hit_reg;

endmodule

`default_nettype wire

// ===== rtl/qoi_variant_image_decoder_core.sv =====
// Top level of the byte-serial QOI variant image decoder.
// Input channel s_*: one stream byte per transfer, header first; s_end_of_data
// marks the last byte, after which a new 12-byte header is expected.
// Result channel m_*: at most one result per input byte, carrying a decoded
// pixel with its repeat count and/or a status code (nonzero flags an error).
// Bytes that cause no result (header bytes, partial ops, ignored bytes) are
// consumed silently.
// The color index is read at the transfer edge at the byte's low six bits, as
// the byte enters the input register; the byte is then decoded against the
// running pixel and loads the result register when that is empty or taken.
// Throughput: one byte per cycle if unstalled, limited by one index read port.
// The receiver may stall: the result register holds, and one more byte waits
// in the input register before s_ready drops.
// Reset (aresetn low, synchronous): decoder awaits a header, running pixel is
// opaque black, and all index entries read as zero.
`default_nettype none

module qoi_variant_image_decoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_pixel_valid,
    output logic [7:0]       m_red,
    output logic [7:0]       m_green,
    output logic [7:0]       m_blue,
    output logic [7:0]       m_alpha,
    output logic [13:0]      m_copies,
    output logic             m_image_done,
    output logic [2:0]       m_status,
    output logic [15:0]      m_image_width,
    output logic [15:0]      m_image_height
);

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       accept;
    logic       fire;

    // decoder state
    logic [3:0]         hdr_pos_reg, hdr_pos_next;
    logic               magic_ok_reg, magic_ok_next;
    logic [15:0]        width_reg, width_next;
    logic [15:0]        height_reg, height_next;
    logic [31:0]        remain_reg, remain_next;
    qoivid_pkg::phase_t phase_reg, phase_next;
    logic [7:0]         op1_reg, op1_next;
    logic [7:0]         op2_reg, op2_next;
    logic [3:0]         mask_reg, mask_next;
    logic [31:0]        pixel_reg, pixel_next;

    // result register
    logic        out_valid_reg;
    logic        out_pix_reg;
    logic [31:0] out_pixel_reg;
    logic [13:0] out_copies_reg;
    logic        out_done_reg;
    logic [2:0]  out_status_reg;
    logic [15:0] out_width_reg;
    logic [15:0] out_height_reg;

    // decode results
    logic                emit;
    logic                pix;
    logic                done;
    logic                store;
    logic                hdr_clear;
    qoivid_pkg::status_t status;
    logic [13:0]         run;
    logic [13:0]         copies_full;
    logic [13:0]         copies;
    logic [7:0]          b;
    logic [7:0]          ch_r, ch_g, ch_b, ch_a;
    logic                decoding;

    qoivid_pkg::idx_wr_t idx_wr;
    logic [31:0]         idx_data;
    logic                idx_hit;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_data_byte;
            in_end_reg  <= s_end_of_data;
        end
    end

    qoivid_index u_index (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (s_data_byte[5:0]),
        .wr      (idx_wr),
        .clr     (fire && hdr_clear),
        .rd_data (idx_data),
        .rd_hit  (idx_hit)
    );

    always_comb begin
        b            = in_byte_reg;
        hdr_pos_next = hdr_pos_reg;
        magic_ok_next = magic_ok_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        remain_next  = remain_reg;
        phase_next   = phase_reg;
        op1_next     = op1_reg;
        op2_next     = op2_reg;
        mask_next    = mask_reg;
        pixel_next   = pixel_reg;
        emit         = 1'b0;
        pix          = 1'b0;
        done         = 1'b0;
        store        = 1'b1;
        hdr_clear    = 1'b0;
        status       = qoivid_pkg::ST_OK;
        run          = '0;
        copies_full  = 14'd1;
        copies       = '0;
        ch_r         = pixel_reg[7:0];
        ch_g         = pixel_reg[15:8];
        ch_b         = pixel_reg[23:16];
        ch_a         = pixel_reg[31:24];

        case (phase_reg)
            qoivid_pkg::PH_HEADER: begin
                if (hdr_pos_reg < 4'd4 &&
                    b != qoivid_pkg::magic_byte(hdr_pos_reg[1:0])) begin
                    magic_ok_next = 1'b0;
                end
                case (hdr_pos_reg)
                    4'd4:    width_next[7:0]   = b;
                    4'd5:    width_next[15:8]  = b;
                    4'd6:    height_next[7:0]  = b;
                    4'd7:    height_next[15:8] = b;
                    default: ;
                endcase
                if (hdr_pos_reg >= qoivid_pkg::HDR_LAST) begin
                    hdr_pos_next = qoivid_pkg::HDR_DONE;
                    if (!magic_ok_next) begin
                        emit       = 1'b1;
                        status     = qoivid_pkg::ST_BAD_MAGIC;
                        phase_next = qoivid_pkg::PH_ERROR;
                    end else if (width_reg == '0 || height_reg == '0) begin
                        emit       = 1'b1;
                        status     = qoivid_pkg::ST_ZERO_SIZE;
                        phase_next = qoivid_pkg::PH_ERROR;
                    end else begin
                        remain_next = {16'd0, width_reg} * {16'd0, height_reg};
                        ch_r        = qoivid_pkg::PIXEL_RESET[7:0];
                        ch_g        = qoivid_pkg::PIXEL_RESET[15:8];
                        ch_b        = qoivid_pkg::PIXEL_RESET[23:16];
                        ch_a        = qoivid_pkg::PIXEL_RESET[31:24];
                        hdr_clear   = 1'b1;
                        phase_next  = qoivid_pkg::PH_OP;
                    end
                end else begin
                    hdr_pos_next = hdr_pos_reg + 4'd1;
                end
            end
            qoivid_pkg::PH_OP: begin
                op1_next = b;
                if (b < qoivid_pkg::OP_RUN) begin
                    {ch_a, ch_b, ch_g, ch_r} = idx_hit ? idx_data : 32'd0;
                    store = 1'b0;
                    pix   = 1'b1;
                end else if (b < qoivid_pkg::OP_LONG_RUN) begin
                    run   = {9'd0, b[4:0]};
                    store = 1'b0;
                    pix   = 1'b1;
                end else if (b < qoivid_pkg::OP_DELTA) begin
                    phase_next = qoivid_pkg::PH_BYTE2;
                end else if (b < qoivid_pkg::OP_MEDIUM) begin
                    ch_r = ch_r + {{6{b[5]}}, b[5:4]};
                    ch_g = ch_g + {{6{b[3]}}, b[3:2]};
                    ch_b = ch_b + {{6{b[1]}}, b[1:0]};
                    pix  = 1'b1;
                end else if (b < qoivid_pkg::OP_LITERAL) begin
                    phase_next = qoivid_pkg::PH_BYTE2;
                end else begin
                    mask_next = b[3:0];
                    if (b[3:0] == 4'd0) begin
                        pix = 1'b1;
                    end else begin
                        phase_next = qoivid_pkg::PH_LITERAL;
                    end
                end
            end
            qoivid_pkg::PH_BYTE2: begin
                if (op1_reg < qoivid_pkg::OP_DELTA) begin
                    run   = {1'b0, op1_reg[4:0], b} + qoivid_pkg::LONG_RUN_BIAS;
                    store = 1'b0;
                    pix   = 1'b1;
                end else if (op1_reg < qoivid_pkg::OP_WIDE) begin
                    ch_r = ch_r + {{3{op1_reg[4]}}, op1_reg[4:0]};
                    ch_g = ch_g + {{4{b[7]}}, b[7:4]};
                    ch_b = ch_b + {{4{b[3]}}, b[3:0]};
                    pix  = 1'b1;
                end else begin
                    op2_next   = b;
                    phase_next = qoivid_pkg::PH_BYTE3;
                end
            end
            qoivid_pkg::PH_BYTE3: begin
                ch_r = ch_r + {{3{op1_reg[3]}}, op1_reg[3:0], op2_reg[7]};
                ch_g = ch_g + {{3{op2_reg[6]}}, op2_reg[6:2]};
                ch_b = ch_b + {{3{op2_reg[1]}}, op2_reg[1:0], b[7:5]};
                ch_a = ch_a + {{3{b[4]}}, b[4:0]};
                pix  = 1'b1;
            end
            qoivid_pkg::PH_LITERAL: begin
                if (mask_reg[3]) begin
                    ch_r         = b;
                    mask_next[3] = 1'b0;
                end else if (mask_reg[2]) begin
                    ch_g         = b;
                    mask_next[2] = 1'b0;
                end else if (mask_reg[1]) begin
                    ch_b         = b;
                    mask_next[1] = 1'b0;
                end else if (mask_reg[0]) begin
                    ch_a         = b;
                    mask_next[0] = 1'b0;
                end
                if (mask_next == 4'd0) begin
                    pix = 1'b1;
                end
            end
            default: ;
        endcase

        pixel_next = {ch_a, ch_b, ch_g, ch_r};

        if (pix) begin
            copies_full = run + 14'd1;
            if ({18'd0, copies_full} > remain_reg) begin
                copies = remain_reg[13:0];
            end else begin
                copies = copies_full;
            end
            remain_next = remain_reg - {18'd0, copies};
            emit        = 1'b1;
            if (remain_next == '0) begin
                done       = 1'b1;
                phase_next = qoivid_pkg::PH_FULL;
            end else begin
                phase_next = qoivid_pkg::PH_OP;
            end
        end

        if (in_end_reg) begin
            case (phase_next)
                qoivid_pkg::PH_HEADER: begin
                    emit   = 1'b1;
                    status = qoivid_pkg::ST_SHORT_HDR;
                end
                qoivid_pkg::PH_BYTE2, qoivid_pkg::PH_BYTE3, qoivid_pkg::PH_LITERAL: begin
                    emit   = 1'b1;
                    status = qoivid_pkg::ST_TRUNC_OP;
                end
                qoivid_pkg::PH_OP: begin
                    emit   = 1'b1;
                    status = qoivid_pkg::ST_INCOMPLETE;
                end
                default: ;
            endcase
        end
    end

    assign idx_wr.en   = fire && pix && store;
    assign idx_wr.addr = ch_r[5:0] ^ ch_g[5:0] ^ ch_b[5:0] ^ ch_a[5:0];
    assign idx_wr.data = pixel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos_reg  <= '0;
            magic_ok_reg <= 1'b1;
            width_reg    <= '0;
            height_reg   <= '0;
            remain_reg   <= '0;
            phase_reg    <= qoivid_pkg::PH_HEADER;
            op1_reg      <= '0;
            op2_reg      <= '0;
            mask_reg     <= '0;
            pixel_reg    <= qoivid_pkg::PIXEL_RESET;
        end else if (fire) begin
            remain_reg <= remain_next;
            op1_reg    <= op1_next;
            op2_reg    <= op2_next;
            pixel_reg  <= pixel_next;
            if (in_end_reg) begin
                hdr_pos_reg  <= '0;
                magic_ok_reg <= 1'b1;
                width_reg    <= '0;
                height_reg   <= '0;
                phase_reg    <= qoivid_pkg::PH_HEADER;
                mask_reg     <= '0;
            end else begin
                hdr_pos_reg  <= hdr_pos_next;
                magic_ok_reg <= magic_ok_next;
                width_reg    <= width_next;
                height_reg   <= height_next;
                phase_reg    <= phase_next;
                mask_reg     <= mask_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            out_pix_reg    <= pix;
            out_pixel_reg  <= pix ? pixel_next : 32'd0;
            out_copies_reg <= pix ? copies : 14'd0;
            out_done_reg   <= done;
            out_status_reg <= status;
            out_width_reg  <= width_next;
            out_height_reg <= height_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_pixel_valid  = out_pix_reg;
    assign m_red          = out_pixel_reg[7:0];
    assign m_green        = out_pixel_reg[15:8];
    assign m_blue         = out_pixel_reg[23:16];
    assign m_alpha        = out_pixel_reg[31:24];
    assign m_copies       = out_copies_reg;
    assign m_image_done   = out_done_reg;
    assign m_status       = out_status_reg;
    assign m_image_width  = out_width_reg;
    assign m_image_height = out_height_reg;

    assign decoding = phase_reg inside {qoivid_pkg::PH_OP, qoivid_pkg::PH_BYTE2,
                                        qoivid_pkg::PH_BYTE3, qoivid_pkg::PH_LITERAL};

`include "qoi_variant_image_decoder_core_assert.svh"

    `QOIVID_ASSERT_NOW(a_full_means_empty, phase_reg == qoivid_pkg::PH_FULL, remain_reg == '0)
    `QOIVID_ASSERT_NOW(a_decoding_has_pixels, decoding, remain_reg != '0)
    `QOIVID_ASSERT_NOW(a_done_has_pixel, m_valid && m_image_done, m_pixel_valid && m_status == qoivid_pkg::ST_OK)
    `QOIVID_ASSERT_NEXT(a_clear_empties_read, fire && hdr_clear && accept, !idx_hit)

endmodule

`default_nettype wire
